// ----- hdl/dbot_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the display buffer ownership table.
// Depends on nothing; the interfaces, the core and the bench import it.
package dbot_pkg;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 64;
    localparam int DIM_W      = 16;
    localparam int PITCH_W    = 20;
    localparam int ROLE_W     = 2;
    localparam int OWNER_W    = 3;
    localparam int SLOT_IN_W  = 8;
    localparam int STAT_W     = 3;
    localparam int SLOT_OUT_W = 6;

    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [OWNER_W-1:0] t_owner;

    localparam t_kind KIND_REGISTER   = 2'd0;
    localparam t_kind KIND_UNREGISTER = 2'd1;
    localparam t_kind KIND_TRANSFER   = 2'd2;
    localparam t_kind KIND_LOOKUP     = 2'd3;

    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_NULL      = 3'd1;
    localparam t_status STAT_ZERO_SIZE = 3'd2;
    localparam t_status STAT_FULL      = 3'd3;
    localparam t_status STAT_OWNERSHIP = 3'd4;
    localparam t_status STAT_INVALID   = 3'd5;

    localparam t_owner OWNER_NONE    = 3'd0;
    localparam t_owner OWNER_QUEUE   = 3'd1;
    localparam t_owner OWNER_DISPLAY = 3'd2;

    typedef struct packed {
        t_kind                 kind;
        logic [ADDR_W-1:0]     address;
        logic [DIM_W-1:0]      width_in;
        logic [DIM_W-1:0]      height_in;
        logic [PITCH_W-1:0]    pitch_in;
        logic [ROLE_W-1:0]     role_in;
        logic [SLOT_IN_W-1:0]  slot_index;
        t_owner                owner_in;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] assigned_slot;
        logic [ADDR_W-1:0]     out_address;
        logic [DIM_W-1:0]      out_width;
        logic [DIM_W-1:0]      out_height;
        logic [PITCH_W-1:0]    out_pitch;
        logic [ROLE_W-1:0]     out_role;
        t_owner                out_owner;
    } t_rsp;

    // One table entry as it is kept in the slot memory.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [PITCH_W-1:0] pitch;
        logic [ROLE_W-1:0]  role;
        t_owner             owner;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

// ----- hdl/dbot_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and response beats.
// Depends on dbot_pkg for the payload types.
interface dbot_cmd_if import dbot_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dbot_rsp_if import dbot_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/dbot_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module dbot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/display_buffer_ownership_table_core.sv -----
`timescale 1ns / 1ps
// Display buffer ownership table. Unregister, transfer and lookup read the addressed slot
// if its index is in range, then answer; a register that passes its early checks scans every
// slot through the memory read port, while a failed check answers without a scan.
// One command is in flight at a time; the next is taken once the response is registered.
// Reset (synchronous, active low) clears the per-slot valid bits and the used count at once,
// so every slot reads as empty on the next cycle with no clearing pass.
module display_buffer_ownership_table_core
    import dbot_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dbot_cmd_if.sink          i_cmd,
    dbot_rsp_if.source        o_rsp
);

    // Slot index width and a counter width that can also hold NUM_SLOTS itself.
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W = $bits(t_slot);

    t_state r_state, n_state;

    // The command being worked on, with the outcome of its early checks.
    t_cmd               r_req;
    logic               r_early_fail;
    t_status            r_early_st;
    logic [IDX_W-1:0]   r_idx;

    // Scan bookkeeping for a register command.
    logic [CNT_W-1:0]   r_scan_idx;
    logic               r_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_dup;
    logic               r_found;
    logic [IDX_W-1:0]   r_free_idx;

    // Entry valid bits: an entry never written since reset reads as all zeros.
    logic [NUM_SLOTS-1:0] r_vld;
    logic                 r_ent_vld;
    logic [CNT_W-1:0]     r_used;

    logic               r_out_vld;
    t_rsp               r_out;

    // Memory port signals.
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENT_W-1:0]   ram_rdata;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_slot              wr_data;

    logic               accept;
    logic               out_room;
    logic               fire;
    logic               used_inc;
    logic               used_dec;
    logic               scan_last;
    logic               early_fail;
    t_status            early_st;
    t_slot              ent;
    t_rsp               n_res;
    t_cmd               cmd;

    assign cmd      = i_cmd.payload;
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_room = !r_out_vld || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // The final scan read comes back in the cycle after the last address is issued.
    assign scan_last = (r_scan_idx == CNT_W'(NUM_SLOTS)) && r_chk_vld;

    // Checks that need no table access: null address, zero size and a full count for
    // a register, an out-of-range slot index for everything else.
    always_comb begin
        early_fail = 1'b0;
        early_st   = STAT_OK;
        if (cmd.kind == KIND_REGISTER) begin
            if (cmd.address == '0) begin
                early_fail = 1'b1;
                early_st   = STAT_NULL;
            end else if (cmd.width_in == '0 || cmd.height_in == '0 || cmd.pitch_in == '0) begin
                early_fail = 1'b1;
                early_st   = STAT_ZERO_SIZE;
            end else if (r_used >= CNT_W'(NUM_SLOTS)) begin
                early_fail = 1'b1;
                early_st   = STAT_FULL;
            end
        end else if ({1'b0, cmd.slot_index} >= (SLOT_IN_W + 1)'(NUM_SLOTS)) begin
            early_fail = 1'b1;
            early_st   = STAT_INVALID;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (cmd.kind == KIND_REGISTER && !early_fail) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs: memory reads and the response hand-off.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cmd.slot_index[IDX_W-1:0];
        fire    = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_en = accept && (cmd.kind != KIND_REGISTER) && !early_fail;
            end
            S_SCAN: begin
                rd_en   = (r_scan_idx < CNT_W'(NUM_SLOTS));
                rd_addr = r_scan_idx[IDX_W-1:0];
            end
            S_FINISH: begin
                fire = out_room;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    dbot_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // The entry as the table sees it: never written means empty.
    assign ent = r_ent_vld ? t_slot'(ram_rdata) : '0;

    // Result of the command and the write-back that goes with it. The write only
    // happens in the cycle the response is registered.
    always_comb begin
        n_res    = '0;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = ent;
        used_inc = 1'b0;
        used_dec = 1'b0;
        if (r_req.kind != KIND_REGISTER) begin
            n_res.assigned_slot = r_req.slot_index[SLOT_OUT_W-1:0];
        end
        if (r_early_fail) begin
            n_res.status = r_early_st;
        end else if (r_req.kind == KIND_REGISTER) begin
            if (r_dup) begin
                n_res.status = STAT_OWNERSHIP;
            end else if (r_found) begin
                n_res.status        = STAT_OK;
                n_res.assigned_slot = SLOT_OUT_W'(r_free_idx);
                wr_en            = fire;
                wr_addr          = r_free_idx;
                wr_data.address  = r_req.address;
                wr_data.width    = r_req.width_in;
                wr_data.height   = r_req.height_in;
                wr_data.pitch    = r_req.pitch_in;
                wr_data.role     = r_req.role_in;
                wr_data.owner    = OWNER_QUEUE;
                used_inc         = 1'b1;
            end else begin
                n_res.status = STAT_FULL;
            end
        end else if (ent.address == '0) begin
            n_res.status = STAT_INVALID;
        end else begin
            case (r_req.kind)
                KIND_UNREGISTER: begin
                    if (ent.owner == OWNER_DISPLAY) begin
                        n_res.status = STAT_OWNERSHIP;
                    end else begin
                        n_res.status    = STAT_OK;
                        wr_en           = fire;
                        wr_data.address = '0;
                        wr_data.owner   = OWNER_NONE;
                        used_dec        = 1'b1;
                    end
                end
                KIND_TRANSFER: begin
                    n_res.status  = STAT_OK;
                    wr_en         = fire;
                    wr_data.owner = r_req.owner_in;
                end
                default: begin
                    n_res.status      = STAT_OK;
                    n_res.out_address = ent.address;
                    n_res.out_width   = ent.width;
                    n_res.out_height  = ent.height;
                    n_res.out_pitch   = ent.pitch;
                    n_res.out_role    = ent.role;
                    n_res.out_owner   = ent.owner;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vld      <= '0;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
            r_scan_idx <= '0;
            r_chk_vld  <= 1'b0;
            r_dup      <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end

            if (fire && used_inc) begin
                r_used <= r_used + CNT_W'(1);
            end else if (fire && used_dec && r_used != '0) begin
                r_used <= r_used - CNT_W'(1);
            end

            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            // Each read issued during the scan is checked in the cycle after it. A matching
            // address blocks the register only while the slot has an owner; the first
            // empty slot seen is the one to fill.
            if (accept) begin
                r_scan_idx <= '0;
                r_chk_vld  <= 1'b0;
                r_dup      <= 1'b0;
                r_found    <= 1'b0;
            end else if (r_state == S_SCAN) begin
                if (rd_en) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                r_chk_vld <= rd_en;
                if (r_chk_vld) begin
                    if (ent.address == r_req.address && ent.owner != OWNER_NONE) begin
                        r_dup <= 1'b1;
                    end
                    if (!r_found && ent.owner == OWNER_NONE && ent.address == '0) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req        <= cmd;
            r_early_fail <= early_fail;
            r_early_st   <= early_st;
            r_idx        <= cmd.slot_index[IDX_W-1:0];
        end
        if (rd_en) begin
            r_ent_vld <= r_vld[rd_addr];
            r_chk_idx <= rd_addr;
        end
        if (r_state == S_SCAN && r_chk_vld && !r_found
            && ent.owner == OWNER_NONE && ent.address == '0) begin
            r_free_idx <= r_chk_idx;
        end
        if (fire) begin
            r_out <= n_res;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for display_buffer_ownership_table_core: directed rows, then random traffic.
// Depends on dbot_pkg, the dbot_cmd_if/dbot_rsp_if channels and the core RTL in hdl.
module testbench;
    import dbot_pkg::*;

    localparam int NUM_SLOTS      = 16;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 876;
    localparam int EPISODE_LEN    = 60;
    localparam int STEADY_FROM    = 300;
    localparam int STEADY_TO      = 450;
    localparam int DRAIN_AT       = 600;
    localparam int HOLD_AT_BEAT   = 500;
    localparam int HOLD_CYCLES    = 150;
    localparam int IDLE_PCT       = 27;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 8;

    // Codes that the package leaves unnamed but that the block stores as given.
    localparam t_owner            OWNER_SPARE = 3'd7;
    localparam logic [ROLE_W-1:0] ROLE_BACK   = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_FRONT  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_SPARE  = 2'd3;

    localparam logic [ADDR_W-1:0]  ADDR_MAX  = '1;
    localparam logic [DIM_W-1:0]   DIM_MAX   = '1;
    localparam logic [PITCH_W-1:0] PITCH_MAX = '1;

    // One row of the directed plan. Where typed is set, the response is written out by
    // hand; otherwise it comes from the shadow table like every random beat.
    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dbot_cmd_if cmd_if ();
    dbot_rsp_if rsp_if ();

    display_buffer_ownership_table_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the slot table, advanced once per accepted command beat.
    t_slot shadow_slots [NUM_SLOTS] = '{default: '0};
    int    shadow_used = 0;

    // Responses owed by the block, oldest first.
    t_rsp  owed_responses [$];

    // Addresses reused by random registers so that duplicates turn up often.
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    t_row  plan [$];
    int    fail_count = 0;

    // While steady is set neither side idles, so the block sees back-to-back beats.
    bit    steady = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Applies one command to the shadow table and returns the response it must produce.
    function automatic t_rsp apply_table_op(input t_cmd c);
        t_rsp r;
        int   free_slot;
        bit   clash;
        int   i;
        r = '0;
        if (c.kind == KIND_REGISTER) begin
            if (c.address == '0) begin
                r.status = STAT_NULL;
            end else if (c.width_in == '0 || c.height_in == '0 || c.pitch_in == '0) begin
                r.status = STAT_ZERO_SIZE;
            end else if (shadow_used >= NUM_SLOTS) begin
                r.status = STAT_FULL;
            end else begin
                clash     = 1'b0;
                free_slot = -1;
                for (i = 0; i < NUM_SLOTS; i++) begin
                    // A slot handed back to no owner keeps its address but does not block.
                    if (shadow_slots[i].address == c.address &&
                        shadow_slots[i].owner != OWNER_NONE) begin
                        clash = 1'b1;
                    end
                    if (free_slot < 0 && shadow_slots[i].owner == OWNER_NONE &&
                        shadow_slots[i].address == '0) begin
                        free_slot = i;
                    end
                end
                if (clash) begin
                    r.status = STAT_OWNERSHIP;
                end else if (free_slot < 0) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_slots[free_slot].address = c.address;
                    shadow_slots[free_slot].width   = c.width_in;
                    shadow_slots[free_slot].height  = c.height_in;
                    shadow_slots[free_slot].pitch   = c.pitch_in;
                    shadow_slots[free_slot].role    = c.role_in;
                    shadow_slots[free_slot].owner   = OWNER_QUEUE;
                    shadow_used++;
                    r.status        = STAT_OK;
                    r.assigned_slot = free_slot[SLOT_OUT_W-1:0];
                end
            end
            return r;
        end

        // Every other operation echoes the low bits of the addressed slot.
        r.assigned_slot = c.slot_index[SLOT_OUT_W-1:0];
        if (c.slot_index >= NUM_SLOTS) begin
            r.status = STAT_INVALID;
            return r;
        end
        if (shadow_slots[c.slot_index].address == '0) begin
            r.status = STAT_INVALID;
            return r;
        end
        r.status = STAT_OK;
        case (c.kind)
            KIND_UNREGISTER: begin
                if (shadow_slots[c.slot_index].owner == OWNER_DISPLAY) begin
                    r.status = STAT_OWNERSHIP;
                end else begin
                    shadow_slots[c.slot_index].address = '0;
                    shadow_slots[c.slot_index].owner   = OWNER_NONE;
                    if (shadow_used > 0) shadow_used--;
                end
            end
            KIND_TRANSFER: begin
                shadow_slots[c.slot_index].owner = c.owner_in;
            end
            default: begin
                r.out_address = shadow_slots[c.slot_index].address;
                r.out_width   = shadow_slots[c.slot_index].width;
                r.out_height  = shadow_slots[c.slot_index].height;
                r.out_pitch   = shadow_slots[c.slot_index].pitch;
                r.out_role    = shadow_slots[c.slot_index].role;
                r.out_owner   = shadow_slots[c.slot_index].owner;
            end
        endcase
        return r;
    endfunction

    function automatic t_row plan_row(input t_kind k, input logic [ADDR_W-1:0] a,
                                      input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                      input logic [PITCH_W-1:0] p,
                                      input logic [ROLE_W-1:0] role,
                                      input logic [SLOT_IN_W-1:0] idx, input t_owner own,
                                      input bit typed, input t_status st,
                                      input logic [SLOT_OUT_W-1:0] slot);
        t_row row;
        row.cmd.kind       = k;
        row.cmd.address    = a;
        row.cmd.width_in   = w;
        row.cmd.height_in  = h;
        row.cmd.pitch_in   = p;
        row.cmd.role_in    = role;
        row.cmd.slot_index = idx;
        row.cmd.owner_in   = own;
        row.typed          = typed;
        row.rsp            = '0;
        row.rsp.status        = st;
        row.rsp.assigned_slot = slot;
        return row;
    endfunction

    // Random command with every field filled at full width, then steered: registers reuse pooled
    // addresses half the time, and slot operations mostly aim at a slot that is in use.
    function automatic t_cmd random_cmd(input int reg_pct);
        t_cmd c;
        int   roll;
        int   live [$];
        int   i;
        c.address    = {$urandom, $urandom};
        c.width_in   = DIM_W'($urandom);
        c.height_in  = DIM_W'($urandom);
        c.pitch_in   = PITCH_W'($urandom);
        c.role_in    = ROLE_W'($urandom);
        c.slot_index = SLOT_IN_W'($urandom);
        c.owner_in   = t_owner'($urandom);
        if ($urandom_range(99) < reg_pct) begin
            c.kind = KIND_REGISTER;
            roll   = $urandom_range(99);
            if (roll < 50) begin
                c.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (roll < 54) begin
                c.address = '0;
            end
            if ($urandom_range(99) < 6) begin
                case ($urandom_range(2))
                    0:       c.width_in  = '0;
                    1:       c.height_in = '0;
                    default: c.pitch_in  = '0;
                endcase
            end
        end else begin
            c.kind = t_kind'($urandom_range(KIND_LOOKUP, KIND_UNREGISTER));
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (shadow_slots[i].address != '0) live.push_back(i);
            end
            roll = $urandom_range(99);
            if (roll < 80 && live.size() != 0) begin
                c.slot_index = SLOT_IN_W'(live[$urandom_range(live.size() - 1)]);
            end else if (roll < 92) begin
                c.slot_index = SLOT_IN_W'($urandom_range(NUM_SLOTS + 1));
            end
        end
        return c;
    endfunction

    // Offers one command beat, records the response it owes once the beat is taken, and
    // then idles at random unless the steady stretch is running.
    task automatic offer_cmd(input t_cmd c, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = apply_table_op(c);
        owed_responses.push_back(typed ? typed_rsp : predicted);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        end
    endtask

    // Stops offering until every owed response has been taken. Valid is only dropped when
    // there is something to wait for, so the next offer never lands in the same time step.
    task automatic await_drain();
        if (owed_responses.size() != 0) begin
            cmd_if.valid <= 1'b0;
            while (owed_responses.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    // Command side: reset, the directed plan, then random episodes.
    initial begin : stimulus
        int n;
        int i;
        int reg_pct;
        cmd_if.valid   <= 1'b0;
        cmd_if.payload <= '0;
        reg_pct = 85;
        for (i = 0; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom} | 64'd1;

        // Empty table: nothing to look up or unregister, then the null and zero-size register
        // checks in their order of priority.
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b1, STAT_INVALID, 6'd0));
        plan.push_back(plan_row(KIND_UNREGISTER, ADDR_MAX, '0, '0, '0, ROLE_BACK, 8'd255,
                                OWNER_SPARE, 1'b1, STAT_INVALID, 6'd63));
        plan.push_back(plan_row(KIND_REGISTER, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b1, STAT_NULL, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, ADDR_MAX, '0, DIM_MAX, PITCH_MAX, ROLE_SPARE,
                                8'd0, OWNER_NONE, 1'b1, STAT_ZERO_SIZE, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, 64'd1, DIM_MAX, '0, PITCH_MAX, ROLE_SPARE,
                                8'd0, OWNER_NONE, 1'b1, STAT_ZERO_SIZE, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, 64'd1, DIM_MAX, DIM_MAX, '0, ROLE_SPARE,
                                8'd0, OWNER_NONE, 1'b1, STAT_ZERO_SIZE, 6'd0));
        // All-ones descriptor lands in the lowest slot; the same address again is refused.
        plan.push_back(plan_row(KIND_REGISTER, ADDR_MAX, DIM_MAX, DIM_MAX, PITCH_MAX,
                                ROLE_SPARE, 8'd255, OWNER_SPARE, 1'b1, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, ADDR_MAX, 16'd1, 16'd1, 20'd1, ROLE_BACK,
                                8'd0, OWNER_NONE, 1'b1, STAT_OWNERSHIP, 6'd0));
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        // Once owned by nobody the address may be registered a second time, into slot 1.
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b1, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, ADDR_MAX, 16'd1, 16'd1, 20'd1, ROLE_FRONT,
                                8'd0, OWNER_NONE, 1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        // A slot held by the display cannot be unregistered.
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd1,
                                OWNER_DISPLAY, 1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_UNREGISTER, '0, '0, '0, '0, ROLE_BACK, 8'd1, OWNER_NONE,
                                1'b1, STAT_OWNERSHIP, 6'd1));
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd1, OWNER_SPARE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd1, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_UNREGISTER, '0, '0, '0, '0, ROLE_BACK, 8'd1, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_UNREGISTER, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b1, STAT_INVALID, 6'd0));
        // Slot indexes just past the table, an empty slot, and one that aliases slot 0.
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd16, OWNER_QUEUE,
                                1'b1, STAT_INVALID, 6'd16));
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd15, OWNER_QUEUE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_REGISTER, 64'd1, 16'd1, 16'd1, 20'd1, ROLE_SPARE - 2'd1,
                                8'd0, OWNER_NONE, 1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_LOOKUP, '0, '0, '0, '0, ROLE_BACK, 8'd0, OWNER_NONE,
                                1'b0, STAT_OK, 6'd0));
        plan.push_back(plan_row(KIND_TRANSFER, '0, '0, '0, '0, ROLE_BACK, 8'd64, OWNER_QUEUE,
                                1'b1, STAT_INVALID, 6'd0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) offer_cmd(plan[r].cmd, plan[r].typed, plan[r].rsp);
        await_drain();

        // Each later episode picks its register share at random: heavy on registers, which drives the
        // table to full, balanced, or light, draining it through unregisters, transfers and lookups.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n != 0 && n % EPISODE_LEN == 0) begin
                case ($urandom_range(2))
                    0:       reg_pct = 85;
                    1:       reg_pct = 50;
                    default: reg_pct = 15;
                endcase
            end
            steady = (n >= STEADY_FROM && n < STEADY_TO);
            if (n == DRAIN_AT) await_drain();
            offer_cmd(random_cmd(reg_pct), 1'b0, '0);
        end

        // Let the last responses come home, then allow one full register scan of slack so
        // that any stray extra beat is caught by the response side.
        await_drain();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Response side: takes beats, compares them with the oldest owed response and drives
    // ready, including one long hold-off that backs the block up into its command port.
    initial begin : response_sink
        t_rsp got;
        t_rsp want;
        int   hold_left;
        int   rsp_beats;
        hold_left = 0;
        rsp_beats = 0;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                rsp_beats++;
                if (owed_responses.size() == 0) begin
                    $error("response beat with none owed, status %0d slot %0d",
                           got.status, got.assigned_slot);
                    fail_count++;
                end else begin
                    want = owed_responses.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
                    check_field("assigned_slot", ADDR_W'(want.assigned_slot),
                                ADDR_W'(got.assigned_slot));
                    check_field("out_address", want.out_address, got.out_address);
                    check_field("out_width", ADDR_W'(want.out_width), ADDR_W'(got.out_width));
                    check_field("out_height", ADDR_W'(want.out_height),
                                ADDR_W'(got.out_height));
                    check_field("out_pitch", ADDR_W'(want.out_pitch), ADDR_W'(got.out_pitch));
                    check_field("out_role", ADDR_W'(want.out_role), ADDR_W'(got.out_role));
                    check_field("out_owner", ADDR_W'(want.out_owner), ADDR_W'(got.out_owner));
                end
                if (rsp_beats == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

endmodule
